### hdl/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg : front/middle/back queue shared definitions
// Operation codes, sequencer state type and fixed constants.
// ----------------------------------------------------------------------------
package fmbq_pkg;

  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int COUNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_MID   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_MID    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd5;

  // value returned when nothing is popped
  localparam logic [DATA_W-1:0] NO_VALUE = '1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_RD  = 7'b0000010,
    S_INS_WR  = 7'b0000100,
    S_INS_FIN = 7'b0001000,
    S_REM_CAP = 7'b0010000,
    S_REM_RD  = 7'b0100000,
    S_REM_WR  = 7'b1000000
  } fmbq_state_t;

endpackage

### hdl/front_middle_back_queue_core.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_core : bounded front/middle/back queue
// Ordered store of signed 32-bit values with push and pop at the front, the
// middle and the back. Gaps are opened and closed one entry at a time through
// a single-port-write / single-port-read memory under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  command  | start / busy       | mode, push_value
//  result   | done (1-cycle)     | pop_value, was_empty, dropped, entry_count
//
//  Sequence: a beat that moves no entry (pop on empty, push into a full store,
//    unused mode) gives its result the cycle after acceptance, busy stays low.
//  A push walks S_INS_RD / S_INS_WR once per moved entry, then writes the new
//    value in S_INS_FIN; a pop captures its value in S_REM_CAP, then walks
//    S_REM_RD / S_REM_WR once per moved entry. Each move is one memory read
//    plus one memory write.
//  Reset: rst (synchronous) empties the queue; stored words are not cleared.
//  Stalls: busy is high from acceptance until the result cycle; the receiver
//    cannot stall, done is a one-cycle strobe.
//
module front_middle_back_queue_core #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fmbq_pkg::MODE_W-1:0]      mode,
  input  logic signed [fmbq_pkg::DATA_W-1:0] push_value,
  output logic                             done,
  output logic signed [fmbq_pkg::DATA_W-1:0] pop_value,
  output logic                             was_empty,
  output logic                             dropped,
  output logic [fmbq_pkg::COUNT_W-1:0]     entry_count
);

  // index width and count width (count reaches CAPACITY)
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [CW-1:0] C_ONE  = CW'(1);
  localparam logic [CW-1:0] C_TWO  = CW'(2);
  localparam logic [CW-1:0] C_FULL = CW'(CAPACITY);

  fmbq_pkg::fmbq_state_t state;

  logic [CW-1:0] count;   // stored values
  logic [CW-1:0] k;       // walking index
  logic [CW-1:0] pos;     // insert / remove position
  logic [fmbq_pkg::DATA_W-1:0] val;

  // storage
  logic [fmbq_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [fmbq_pkg::DATA_W-1:0] rd_data;
  logic [IW-1:0]               rd_addr;
  logic [IW-1:0]               wr_addr;
  logic [fmbq_pkg::DATA_W-1:0] wr_data;
  logic                        wr_en;

  // command decode
  logic          is_push;
  logic          is_pop;
  logic          full;
  logic          empty;
  logic [CW-1:0] half;
  logic [CW-1:0] push_pos;
  logic [CW-1:0] pop_pos;

  assign busy = (state != fmbq_pkg::S_IDLE);

  assign is_push = (mode == fmbq_pkg::MODE_PUSH_FRONT) || (mode == fmbq_pkg::MODE_PUSH_MID) ||
                   (mode == fmbq_pkg::MODE_PUSH_BACK);
  assign is_pop  = (mode == fmbq_pkg::MODE_POP_FRONT) || (mode == fmbq_pkg::MODE_POP_MID) ||
                   (mode == fmbq_pkg::MODE_POP_BACK);
  assign full  = (count == C_FULL);
  assign empty = (count == '0);
  assign half  = count >> 1;

  always_comb begin
    unique case (mode)
      fmbq_pkg::MODE_PUSH_FRONT: push_pos = '0;
      fmbq_pkg::MODE_PUSH_MID:   push_pos = half;
      default:                   push_pos = count;
    endcase
  end

  // middle pop: count/2 when odd, count/2-1 when even
  always_comb begin
    unique case (mode)
      fmbq_pkg::MODE_POP_FRONT: pop_pos = '0;
      fmbq_pkg::MODE_POP_MID:   pop_pos = count[0] ? half : (half - C_ONE);
      default:                  pop_pos = count - C_ONE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = k[IW-1:0];
    wr_data = rd_data;
    unique case (state)
      fmbq_pkg::S_IDLE:    rd_addr = pop_pos[IW-1:0];   // first read of a pop
      fmbq_pkg::S_INS_RD:  rd_addr = IW'(k - C_ONE);
      fmbq_pkg::S_INS_WR:  wr_en   = 1'b1;              // shift up by one
      fmbq_pkg::S_INS_FIN: begin
        wr_en   = 1'b1;
        wr_addr = pos[IW-1:0];
        wr_data = val;
      end
      fmbq_pkg::S_REM_RD:  rd_addr = IW'(k + C_ONE);
      fmbq_pkg::S_REM_WR:  wr_en   = 1'b1;              // shift down by one
      default:             rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmbq_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        fmbq_pkg::S_IDLE: begin
          if (start) begin
            val <= push_value;
            if (is_push && !full) begin
              pos   <= push_pos;
              k     <= count;
              state <= (count > push_pos) ? fmbq_pkg::S_INS_RD : fmbq_pkg::S_INS_FIN;
            end else if (is_pop && !empty) begin
              pos   <= pop_pos;
              state <= fmbq_pkg::S_REM_CAP;
            end else begin
              // nothing moves: answer at once
              done        <= 1'b1;
              pop_value   <= fmbq_pkg::NO_VALUE;
              was_empty   <= is_pop;
              dropped     <= is_push;
              entry_count <= fmbq_pkg::COUNT_W'(count);
            end
          end
        end
        fmbq_pkg::S_INS_RD: state <= fmbq_pkg::S_INS_WR;
        fmbq_pkg::S_INS_WR: begin
          k     <= k - C_ONE;
          state <= (k > pos + C_ONE) ? fmbq_pkg::S_INS_RD : fmbq_pkg::S_INS_FIN;
        end
        fmbq_pkg::S_INS_FIN: begin
          count       <= count + C_ONE;
          done        <= 1'b1;
          pop_value   <= fmbq_pkg::NO_VALUE;
          was_empty   <= 1'b0;
          dropped     <= 1'b0;
          entry_count <= fmbq_pkg::COUNT_W'(count + C_ONE);
          state       <= fmbq_pkg::S_IDLE;
        end
        fmbq_pkg::S_REM_CAP: begin
          pop_value <= rd_data;
          k         <= pos;
          if (pos + C_ONE < count) begin
            state <= fmbq_pkg::S_REM_RD;
          end else begin
            count       <= count - C_ONE;
            done        <= 1'b1;
            was_empty   <= 1'b0;
            dropped     <= 1'b0;
            entry_count <= fmbq_pkg::COUNT_W'(count - C_ONE);
            state       <= fmbq_pkg::S_IDLE;
          end
        end
        fmbq_pkg::S_REM_RD: state <= fmbq_pkg::S_REM_WR;
        fmbq_pkg::S_REM_WR: begin
          k <= k + C_ONE;
          if (k + C_TWO < count) begin
            state <= fmbq_pkg::S_REM_RD;
          end else begin
            count       <= count - C_ONE;
            done        <= 1'b1;
            was_empty   <= 1'b0;
            dropped     <= 1'b0;
            entry_count <= fmbq_pkg::COUNT_W'(count - C_ONE);
            state       <= fmbq_pkg::S_IDLE;
          end
        end
        default: state <= fmbq_pkg::S_IDLE;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= C_FULL)
    else $error("count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == fmbq_pkg::S_IDLE))
    else $error("result strobe while sequencer busy");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_pop && empty) |=> (done && was_empty && !dropped))
    else $error("pop on empty not answered at once");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_push && full) |=> (done && dropped && $stable(count)))
    else $error("push into full store not dropped");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

endmodule
